// ----- design/apc_pkg.sv -----
package apc_pkg;

  localparam int PEN_W = 26;
  localparam int CNT_OUT_W = 7;

  localparam logic [PEN_W-1:0] PEN_MAX = 26'd65536000;
  localparam logic [PEN_W-1:0] PEN_MIN = 26'd6554;
  localparam logic [PEN_W-1:0] PEN_ONE = 26'd65536;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_ADJUST = 2'd1;
  localparam logic [1:0] CMD_LOAD   = 2'd2;

  localparam logic [1:0] CFG_TARGET_COUNT   = 2'd0;
  localparam logic [1:0] CFG_BAND_COUNT     = 2'd1;
  localparam logic [1:0] CFG_START_CAPACITY = 2'd2;
  localparam logic [1:0] CFG_START_DURATION = 2'd3;

  // Window update request sent from the top level to the window tracker.
  typedef struct packed {
    logic rec;
    logic fill;
    logic load_ok;
    logic duration_ok;
  } apc_win_cmd_t;

  typedef struct packed {
    logic [PEN_W-1:0]     capacity_penalty;
    logic [PEN_W-1:0]     duration_penalty;
    logic [CNT_OUT_W-1:0] load_feasible_count;
    logic [CNT_OUT_W-1:0] duration_feasible_count;
  } apc_result_t;

endpackage

// ----- design/apc_ram.sv -----
module apc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/apc_window.sv -----
module apc_window #(
  parameter int WINDOW = 100,
  parameter int CNT_W  = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  apc_pkg::apc_win_cmd_t win_cmd,
  output logic [CNT_W-1:0]      load_ones,
  output logic [CNT_W-1:0]      duration_ones,
  output logic [CNT_W-1:0]      load_ones_nxt,
  output logic [CNT_W-1:0]      duration_ones_nxt
);

  import apc_pkg::*;

  localparam int PTR_W = $clog2(WINDOW);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic             wrapped_r, wrapped_nxt;
  logic [CNT_W-1:0] load_ones_r, duration_ones_r;
  logic [1:0]       rd_data;
  logic [1:0]       old_bits;

  // Every slot at or above the pointer still holds its fill value until the
  // pointer has gone once around, so only wrapped slots come from the RAM.
  assign old_bits = wrapped_r ? rd_data : 2'b11;

  always_comb begin
    ptr_nxt           = ptr_r;
    wrapped_nxt       = wrapped_r;
    load_ones_nxt     = load_ones_r;
    duration_ones_nxt = duration_ones_r;
    if (win_cmd.fill) begin
      ptr_nxt           = '0;
      wrapped_nxt       = 1'b0;
      load_ones_nxt     = CNT_W'(WINDOW);
      duration_ones_nxt = CNT_W'(WINDOW);
    end else if (win_cmd.rec) begin
      load_ones_nxt     = load_ones_r - CNT_W'(old_bits[1]) + CNT_W'(win_cmd.load_ok);
      duration_ones_nxt = duration_ones_r - CNT_W'(old_bits[0])
                          + CNT_W'(win_cmd.duration_ok);
      if (ptr_r == PTR_LAST) begin
        ptr_nxt     = '0;
        wrapped_nxt = 1'b1;
      end else begin
        ptr_nxt = ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r           <= '0;
      wrapped_r       <= 1'b0;
      load_ones_r     <= CNT_W'(WINDOW);
      duration_ones_r <= CNT_W'(WINDOW);
    end else begin
      ptr_r           <= ptr_nxt;
      wrapped_r       <= wrapped_nxt;
      load_ones_r     <= load_ones_nxt;
      duration_ones_r <= duration_ones_nxt;
    end
  end

  // The read address runs one step ahead, so the oldest pair of the next
  // record is already registered when that record arrives.
  apc_ram #(
    .WIDTH (2),
    .DEPTH (WINDOW)
  ) u_history (
    .clk     (clk),
    .wr_en   (win_cmd.rec && !win_cmd.fill),
    .wr_addr (ptr_r),
    .wr_data ({win_cmd.load_ok, win_cmd.duration_ok}),
    .rd_addr (ptr_nxt),
    .rd_data (rd_data)
  );

  assign load_ones     = load_ones_r;
  assign duration_ones = duration_ones_r;

endmodule

// ----- design/apc_penalty_adjust.sv -----
module apc_penalty_adjust #(
  parameter int CNT_W = 7
) (
  input  logic [apc_pkg::PEN_W-1:0]     pen,
  input  logic [CNT_W-1:0]              count,
  input  logic [apc_pkg::CNT_OUT_W-1:0] target_count,
  input  logic [apc_pkg::CNT_OUT_W-1:0] band_count,
  output logic [apc_pkg::PEN_W-1:0]     pen_nxt
);

  import apc_pkg::*;

  localparam int CMP_W = ((CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W) + 2;
  localparam logic [29:0] RECIP5 = 30'd858993459;

  // Floor of x / 5: reciprocal estimate that is at most one low, then fixed.
  function automatic logic [26:0] div5(input logic [28:0] x);
    logic [58:0] prod;
    logic [26:0] q0;
    logic [28:0] five_q;
    logic [28:0] rem;
    prod   = x * RECIP5;
    q0     = prod[58:32];
    five_q = {q0, 2'b00} + 29'(q0);
    rem    = x - five_q;
    return (rem >= 29'd5) ? q0 + 27'd1 : q0;
  endfunction

  logic signed [CMP_W-1:0] c_s, t_s, b_s, lo_s, hi_s;
  logic [26:0] up_v;
  logic [30:0] x17;
  logic [26:0] dn_v;

  always_comb begin
    c_s  = $signed(CMP_W'(count));
    t_s  = $signed(CMP_W'(target_count));
    b_s  = $signed(CMP_W'(band_count));
    lo_s = t_s - b_s;
    hi_s = t_s + b_s;

    up_v = 27'(pen) + div5(29'(pen));
    x17  = {1'b0, pen, 4'b0000} + 31'(pen);
    dn_v = div5(x17[30:2]);

    pen_nxt = pen;
    if (c_s < lo_s && pen < PEN_MAX) begin
      pen_nxt = (up_v > 27'(PEN_MAX)) ? PEN_MAX : up_v[PEN_W-1:0];
    end else if (c_s > hi_s && pen > PEN_MIN) begin
      pen_nxt = (dn_v < 27'(PEN_MIN)) ? PEN_MIN : dn_v[PEN_W-1:0];
    end
  end

endmodule

// ----- design/adaptive_penalty_controller_unit.sv -----
// Adaptive penalty controller. Each transfer on the input channel is a record
// (push one load/duration feasibility pair into two sliding windows of WINDOW
// outcomes), an adjust (scale each penalty by 1.2 or 0.85 when its feasible
// count leaves target_count +/- band_count, held within 0.1 .. 1000 in Q10.16),
// or a load (refill both windows with feasible outcomes and take the start
// penalties, saturated into range). Command code 3 changes nothing. Every
// input transfer yields exactly one result transfer carrying both penalties
// and the low seven bits of both counts after the command. The block takes one
// item per clock while the skid register is free: all work is one pass of logic
// between the accepted item and the result or skid register. A two-deep output
// stage (result register plus skid register) lets the input take one more item
// while the result side stalls. The history bits live in one RAM of WINDOW
// two-bit entries; no clearing pass is needed after reset or load, since slots
// not written since then are taken as feasible without reading the RAM.
// Configuration writes are accepted whenever reset is released and are meant
// for idle periods. Neither channel accepts anything while reset is held.
module adaptive_penalty_controller_unit #(
  parameter int WINDOW = 100
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [apc_pkg::PEN_W-1:0]         cfg_data,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_cmd,
  input  logic                              in_load_ok,
  input  logic                              in_duration_ok,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [apc_pkg::PEN_W-1:0]         out_capacity_penalty,
  output logic [apc_pkg::PEN_W-1:0]         out_duration_penalty,
  output logic [apc_pkg::CNT_OUT_W-1:0]     out_load_feasible_count,
  output logic [apc_pkg::CNT_OUT_W-1:0]     out_duration_feasible_count
);

  import apc_pkg::*;

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int CNT_X_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

  // Configuration registers.
  logic [CNT_OUT_W-1:0] target_count_r, band_count_r;
  logic [PEN_W-1:0]     start_cap_r, start_dur_r;

  // Penalty state.
  logic [PEN_W-1:0] cap_pen_r, cap_pen_nxt;
  logic [PEN_W-1:0] dur_pen_r, dur_pen_nxt;
  logic [PEN_W-1:0] cap_adj, dur_adj;

  // Output register and skid register.
  logic        out_valid_r, skid_valid_r;
  apc_result_t out_data_r, skid_data_r;
  apc_result_t result;

  logic         in_fire;
  apc_win_cmd_t win_cmd;
  logic [CNT_W-1:0]   load_ones, duration_ones, load_ones_nxt, duration_ones_nxt;
  logic [CNT_X_W-1:0] load_ones_x, duration_ones_x;

  function automatic logic [PEN_W-1:0] clamp_pen(input logic [PEN_W-1:0] p);
    if (p > PEN_MAX) begin
      return PEN_MAX;
    end else if (p < PEN_MIN) begin
      return PEN_MIN;
    end
    return p;
  endfunction

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_count_r <= 7'd20;
      band_count_r   <= 7'd5;
      start_cap_r    <= PEN_ONE;
      start_dur_r    <= PEN_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TARGET_COUNT:   target_count_r <= cfg_data[CNT_OUT_W-1:0];
        CFG_BAND_COUNT:     band_count_r   <= cfg_data[CNT_OUT_W-1:0];
        CFG_START_CAPACITY: start_cap_r    <= cfg_data;
        CFG_START_DURATION: start_dur_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A new item is taken whenever the skid register is free.
  assign in_ready = rst_n && !skid_valid_r;
  assign in_fire  = in_valid && in_ready;

  assign win_cmd = '{rec:         in_fire && (in_cmd == CMD_RECORD),
                     fill:        in_fire && (in_cmd == CMD_LOAD),
                     load_ok:     in_load_ok,
                     duration_ok: in_duration_ok};

  apc_window #(
    .WINDOW (WINDOW),
    .CNT_W  (CNT_W)
  ) u_window (
    .clk               (clk),
    .rst_n             (rst_n),
    .win_cmd           (win_cmd),
    .load_ones         (load_ones),
    .duration_ones     (duration_ones),
    .load_ones_nxt     (load_ones_nxt),
    .duration_ones_nxt (duration_ones_nxt)
  );

  // The adjust decision uses the counts as they stand before the item.
  apc_penalty_adjust #(
    .CNT_W (CNT_W)
  ) u_adjust_capacity (
    .pen          (cap_pen_r),
    .count        (load_ones),
    .target_count (target_count_r),
    .band_count   (band_count_r),
    .pen_nxt      (cap_adj)
  );

  apc_penalty_adjust #(
    .CNT_W (CNT_W)
  ) u_adjust_duration (
    .pen          (dur_pen_r),
    .count        (duration_ones),
    .target_count (target_count_r),
    .band_count   (band_count_r),
    .pen_nxt      (dur_adj)
  );

  always_comb begin
    cap_pen_nxt = cap_pen_r;
    dur_pen_nxt = dur_pen_r;
    if (in_fire) begin
      case (in_cmd)
        CMD_ADJUST: begin
          cap_pen_nxt = cap_adj;
          dur_pen_nxt = dur_adj;
        end
        CMD_LOAD: begin
          cap_pen_nxt = clamp_pen(start_cap_r);
          dur_pen_nxt = clamp_pen(start_dur_r);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_pen_r <= PEN_ONE;
      dur_pen_r <= PEN_ONE;
    end else begin
      cap_pen_r <= cap_pen_nxt;
      dur_pen_r <= dur_pen_nxt;
    end
  end

  // The result carries the state after the item; counts keep their low bits.
  assign load_ones_x     = CNT_X_W'(load_ones_nxt);
  assign duration_ones_x = CNT_X_W'(duration_ones_nxt);

  assign result = '{capacity_penalty:        cap_pen_nxt,
                    duration_penalty:        dur_pen_nxt,
                    load_feasible_count:     load_ones_x[CNT_OUT_W-1:0],
                    duration_feasible_count: duration_ones_x[CNT_OUT_W-1:0]};

  // A result goes to the skid register only when the output register is
  // full and not being drained in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_data_r <= result;
      end else begin
        out_data_r <= result;
      end
    end
  end

  assign out_valid                   = out_valid_r;
  assign out_capacity_penalty        = out_data_r.capacity_penalty;
  assign out_duration_penalty        = out_data_r.duration_penalty;
  assign out_load_feasible_count     = out_data_r.load_feasible_count;
  assign out_duration_feasible_count = out_data_r.duration_feasible_count;

endmodule
